FILE: rtl/core/tepq_pkg.sv
// Package for the timer expiry priority queue.
// It holds the item and result structs, the result kinds, the state type and
// the command and status structs. It has no dependencies.
`timescale 1ns / 1ps
package tepq_pkg;

    localparam int MODE_W = 2;
    localparam int HANDLE_W = 10;
    localparam int TIMEOUT_W = 20;
    localparam int NOW_W = 24;
    localparam int DEADLINE_W = 25;
    localparam int KIND_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 2'd0,
        MODE_CANCEL = 2'd1,
        MODE_EXPIRE = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED       = 3'd0,
        KIND_FULL        = 3'd1,
        KIND_CANCEL_HIT  = 3'd2,
        KIND_CLOSE       = 3'd3,
        KIND_DONE        = 3'd4,
        KIND_CANCEL_MISS = 3'd5
    } t_kind;

    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [HANDLE_W-1:0]  conn_handle;
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [NOW_W-1:0]     now_ms;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] out_handle;
        logic                last;
    } t_result;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Handle source of a result.
    typedef enum logic [1:0] {
        HSEL_ITEM  = 2'd0,
        HSEL_FRONT = 2'd1,
        HSEL_ZERO  = 2'd2
    } t_hsel;

    typedef struct packed {
        logic  load;
        logic  add;
        logic  cancel;
        logic  pop;
        logic  emit;
        t_kind kind;
        t_hsel hsel;
        logic  last;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  full;
        logic  empty;
        logic  front_del;
        logic  front_due;
        logic  hit;
    } t_stat;

endpackage

FILE: rtl/core/timer_expiry_priority_queue.sv
// Top level of the timer expiry priority queue.
// It joins tepq_ctrl and tepq_datapath and registers the results; depends on tepq_pkg.
`timescale 1ns / 1ps
// Deadline-ordered timer queue with lazy deletion. A transaction is taken when
// i_start is high and o_busy is low. Add and cancel latch the item, then update
// the cell chain. An expiry latches the item, then pops entries one per cycle
// from the front cell, then gives its done result.
// Each result is shown on o_result with o_strobe high for one cycle; the receiver
// cannot stall it, and the last result of a transaction has last set.
module timer_expiry_priority_queue #(
    parameter int QUEUE_DEPTH = 32,
    parameter int HANDLE_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  tepq_pkg::t_item   i_item,
    output logic              o_busy,
    output logic              o_strobe,
    output tepq_pkg::t_result o_result
);
    import tepq_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_result res;

    tepq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    tepq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= cmd.emit;
        end
        if (cmd.emit) begin
            o_result <= res;
        end
    end

    // The final result of a transaction appears once the block is free again.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |-> !o_busy)
        else $error("final result while busy");

    // Busy only starts from an accepted transaction.
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy without start");

    // Close results never carry the last flag.
    a_close_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.kind == KIND_CLOSE) |-> !o_result.last)
        else $error("close result marked last");

endmodule

FILE: rtl/core/tepq_ctrl.sv
// Controller of the timer expiry priority queue.
// It sequences add, cancel and expiry transactions; depends on tepq_pkg.
`timescale 1ns / 1ps
module tepq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  tepq_pkg::t_stat i_stat,
    output tepq_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import tepq_pkg::*;

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.kind = KIND_DONE;
        o_cmd.hsel = HSEL_ITEM;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (i_stat.mode)
                    MODE_ADD: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                        o_cmd.add = !i_stat.full;
                        o_cmd.kind = i_stat.full ? KIND_FULL : KIND_ADDED;
                        n_state = ST_IDLE;
                    end
                    MODE_CANCEL: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                        o_cmd.cancel = 1'b1;
                        o_cmd.kind = i_stat.hit ? KIND_CANCEL_HIT : KIND_CANCEL_MISS;
                        n_state = ST_IDLE;
                    end
                    MODE_EXPIRE: begin
                        // Pop one entry a cycle; deleted entries leave silently.
                        if (!i_stat.empty && i_stat.front_del) begin
                            o_cmd.pop = 1'b1;
                        end else if (!i_stat.empty && i_stat.front_due) begin
                            o_cmd.pop = 1'b1;
                            o_cmd.emit = 1'b1;
                            o_cmd.kind = KIND_CLOSE;
                            o_cmd.hsel = HSEL_FRONT;
                        end else begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                            o_cmd.kind = KIND_DONE;
                            o_cmd.hsel = HSEL_ZERO;
                            n_state = ST_IDLE;
                        end
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/tepq_datapath.sv
// Datapath of the timer expiry priority queue: the sorted cell chain and the
// latched item. It depends on tepq_pkg.
`timescale 1ns / 1ps
module tepq_datapath #(
    parameter int QUEUE_DEPTH = 32,
    parameter int HANDLE_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tepq_pkg::t_item   i_item,
    input  tepq_pkg::t_cmd    i_cmd,
    output tepq_pkg::t_stat   o_stat,
    output tepq_pkg::t_result o_result
);
    import tepq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [HANDLE_W-1:0] HMASK =
        (HANDLE_BITS >= HANDLE_W) ? {HANDLE_W{1'b1}} : HANDLE_W'((1 << HANDLE_BITS) - 1);

    logic [DEADLINE_W-1:0] r_dl  [QUEUE_DEPTH];
    logic [HANDLE_W-1:0]   r_hd  [QUEUE_DEPTH];
    logic                  r_del [QUEUE_DEPTH];
    logic [CW-1:0]         r_cnt;
    t_mode                 r_mode;
    logic [HANDLE_W-1:0]   r_handle;
    logic [DEADLINE_W-1:0] r_new_dl;
    logic [NOW_W-1:0]      r_now;

    logic [QUEUE_DEPTH-1:0] gt, ins, valid, match;

    // Latch the accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NONE;
        end else if (i_cmd.load) begin
            r_mode <= t_mode'(i_item.mode);
        end
        if (i_cmd.load) begin
            r_handle <= i_item.conn_handle & HMASK;
            r_new_dl <= {1'b0, i_item.now_ms} + DEADLINE_W'(i_item.timeout_ms);
            r_now    <= i_item.now_ms;
        end
    end

    // Per-cell compare against the new deadline and the cancel handle.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            valid[i] = (CW'(i) < r_cnt);
            gt[i]    = valid[i] && (r_dl[i] > r_new_dl);
            ins[i]   = gt[i] || (CW'(i) == r_cnt);
            match[i] = valid[i] && (r_hd[i] == r_handle) && !r_del[i];
        end
    end

    // Cell chain: insert shifts right, pop shifts left.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_cmd.add) begin
                if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
                    r_dl[i]  <= r_dl[(i > 0) ? i - 1 : 0];
                    r_hd[i]  <= r_hd[(i > 0) ? i - 1 : 0];
                    r_del[i] <= r_del[(i > 0) ? i - 1 : 0];
                end else if (ins[i]) begin
                    r_dl[i]  <= r_new_dl;
                    r_hd[i]  <= r_handle;
                    r_del[i] <= 1'b0;
                end
            end else if (i_cmd.cancel) begin
                if (match[i]) begin
                    r_del[i] <= 1'b1;
                end
            end else if (i_cmd.pop && i < QUEUE_DEPTH - 1) begin
                r_dl[i]  <= r_dl[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                r_hd[i]  <= r_hd[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                r_del[i] <= r_del[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    // Fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.add) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Status to the controller.
    assign o_stat.mode      = r_mode;
    assign o_stat.full      = (r_cnt >= CW'(QUEUE_DEPTH));
    assign o_stat.empty     = (r_cnt == '0);
    assign o_stat.front_del = r_del[0];
    assign o_stat.front_due = ({1'b0, r_now} >= r_dl[0]);
    assign o_stat.hit       = |match;

    // Result fields.
    always_comb begin
        o_result.kind = i_cmd.kind;
        o_result.last = i_cmd.last;
        case (i_cmd.hsel)
            HSEL_FRONT: o_result.out_handle = r_hd[0];
            HSEL_ZERO:  o_result.out_handle = '0;
            default:    o_result.out_handle = r_handle;
        endcase
    end

endmodule
